// ===== hw/rtl/lsar_pkg.sv =====
// Package for the light sensor auto-ranging core: field widths, range codes,
// configuration register indexes, reset values and the configuration struct.
// No dependencies.
`timescale 1ns / 1ps

package lsar_pkg;

  localparam int SlotW    = 2;
  localparam int CountW   = 16;
  localparam int ValueW   = 24;
  localparam int RangeW   = 2;
  localparam int GainW    = 8;
  localparam int ModesW   = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  // Range codes; a mode field uses the same codes plus auto
  localparam logic [RangeW-1:0] RANGE_LOW    = 2'd0;
  localparam logic [RangeW-1:0] RANGE_MEDIUM = 2'd1;
  localparam logic [RangeW-1:0] RANGE_HIGH   = 2'd2;
  localparam logic [RangeW-1:0] MODE_AUTO    = 2'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLowUpper    = 3'd0,
    CfgMediumUpper = 3'd1,
    CfgMargin      = 3'd2,
    CfgGainLow     = 3'd3,
    CfgGainMedium  = 3'd4,
    CfgGainHigh    = 3'd5,
    CfgRangeModes  = 3'd6
  } cfg_idx_e;

  localparam logic [ValueW-1:0] LowUpperRst    = 24'd60000;
  localparam logic [ValueW-1:0] MediumUpperRst = 24'd120000;
  localparam logic [ValueW-1:0] MarginRst      = 24'd5000;
  localparam logic [GainW-1:0]  GainLowRst     = 8'd1;
  localparam logic [GainW-1:0]  GainMediumRst  = 8'd2;
  localparam logic [GainW-1:0]  GainHighRst    = 8'd4;
  localparam logic [ModesW-1:0] RangeModesRst  = 8'hff;

  typedef struct packed {
    logic [ValueW-1:0] low_upper;
    logic [ValueW-1:0] medium_upper;
    logic [ValueW-1:0] margin;
    logic [GainW-1:0]  gain_low;
    logic [GainW-1:0]  gain_medium;
    logic [GainW-1:0]  gain_high;
  } range_cfg_t;

endpackage

// ===== hw/rtl/lsar_if.sv =====
// Channel interfaces of the light sensor auto-ranging core: reading input,
// result output and configuration write. Depends on lsar_pkg.
`timescale 1ns / 1ps

interface lsar_in_if;
  import lsar_pkg::*;
  logic              valid;
  logic              ready;
  logic [SlotW-1:0]  sensor_slot;
  logic [CountW-1:0] raw_count;
  modport source (output valid, output sensor_slot, output raw_count, input ready);
  modport sink   (input valid, input sensor_slot, input raw_count, output ready);
endinterface

interface lsar_out_if;
  import lsar_pkg::*;
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] scaled_value;
  logic [RangeW-1:0] next_range;
  logic              range_changed;
  modport source (output valid, output scaled_value, output next_range,
                  output range_changed, input ready);
  modport sink   (input valid, input scaled_value, input next_range,
                  input range_changed, output ready);
endinterface

interface lsar_cfg_if;
  import lsar_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/lsar_range_calc.sv =====
// Scaling and hysteresis decision for one reading: gain select, multiply and
// limit compares. Pure combinational. Depends on lsar_pkg.
`timescale 1ns / 1ps

module lsar_range_calc (
  input  lsar_pkg::range_cfg_t          cfg_i,
  input  logic [lsar_pkg::RangeW-1:0]   mode_i,
  input  logic [lsar_pkg::RangeW-1:0]   auto_range_i,
  input  logic [lsar_pkg::CountW-1:0]   raw_count_i,
  output logic [lsar_pkg::ValueW-1:0]   scaled_value_o,
  output logic [lsar_pkg::RangeW-1:0]   next_range_o,
  output logic                          range_changed_o
);
  import lsar_pkg::*;

  logic [RangeW-1:0] cur_range;
  logic [GainW-1:0]  gain;
  logic [ValueW-1:0] value;
  logic              below_low;
  logic              below_medium;
  logic [RangeW-1:0] next_range;

  always_comb begin
    if (mode_i == MODE_AUTO) begin
      cur_range = (auto_range_i == MODE_AUTO) ? RANGE_MEDIUM : auto_range_i;
    end else begin
      cur_range = mode_i;
    end
  end

  always_comb begin
    case (cur_range)
      RANGE_LOW:  gain = cfg_i.gain_low;
      RANGE_HIGH: gain = cfg_i.gain_high;
      default:    gain = cfg_i.gain_medium;
    endcase
  end

  // 16 x 8 product fits the 24-bit result exactly
  assign value = ValueW'(raw_count_i) * ValueW'(gain);

  // A step-down threshold that would go negative never fires
  assign below_low    = (cfg_i.low_upper >= cfg_i.margin) &&
                        (value < (cfg_i.low_upper - cfg_i.margin));
  assign below_medium = (cfg_i.medium_upper >= cfg_i.margin) &&
                        (value < (cfg_i.medium_upper - cfg_i.margin));

  always_comb begin
    next_range = cur_range;
    if (mode_i == MODE_AUTO) begin
      case (cur_range)
        RANGE_LOW: begin
          if (value >= cfg_i.low_upper) next_range = RANGE_MEDIUM;
        end
        RANGE_MEDIUM: begin
          if (value >= cfg_i.medium_upper) next_range = RANGE_HIGH;
          else if (below_low)              next_range = RANGE_LOW;
        end
        default: begin
          if (below_medium) next_range = RANGE_MEDIUM;
        end
      endcase
    end
  end

  assign scaled_value_o  = value;
  assign next_range_o    = next_range;
  assign range_changed_o = (mode_i == MODE_AUTO) && (next_range != cur_range);

endmodule

// ===== hw/rtl/light_sensor_auto_ranging_core.sv =====
// Light sensor auto-ranging core: input register, per-slot auto range state,
// result register. Depends on lsar_pkg, lsar_if.sv and lsar_range_calc.
//
//  channel  | dir | payload                                   | transfer when
//  ---------+-----+-------------------------------------------+---------------
//  in_i     | in  | sensor_slot[1:0], raw_count[15:0]         | valid & ready
//  out_o    | out | scaled_value[23:0], next_range[1:0],      | valid & ready
//           |     | range_changed                             |
//  cfg_i    | in  | index[2:0], data[23:0]                    | valid & ready
//
// One reading per cycle sustained while the output is not stalled; a reading
// passes through the input register, then the result register, to the output.
// The slot's auto range is updated as the reading moves into the result
// register, so a following reading of the same slot sees it.
// Output stalls hold the result register and back-pressure the input register.
// Reset restores register defaults and sets every auto range to medium.
// cfg_i is always ready; a write to range_modes also resets every auto range.
`timescale 1ns / 1ps

module light_sensor_auto_ranging_core #(
  parameter int SENSOR_SLOTS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  lsar_cfg_if.sink           cfg_i,
  lsar_in_if.sink            in_i,
  lsar_out_if.source         out_o
);
  import lsar_pkg::*;

  localparam int SlotIdxW = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;
  localparam logic [4:0] SlotsC = 5'(SENSOR_SLOTS);

  // Configuration registers
  range_cfg_t        cfg_q;
  logic [ModesW-1:0] modes_q;
  logic              cfg_we;
  logic              modes_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid & cfg_i.ready;
  assign modes_we    = cfg_we && (cfg_i.index == CfgRangeModes);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_upper    <= LowUpperRst;
      cfg_q.medium_upper <= MediumUpperRst;
      cfg_q.margin       <= MarginRst;
      cfg_q.gain_low     <= GainLowRst;
      cfg_q.gain_medium  <= GainMediumRst;
      cfg_q.gain_high    <= GainHighRst;
      modes_q            <= RangeModesRst;
    end else if (cfg_we) begin
      case (cfg_i.index)
        CfgLowUpper:    cfg_q.low_upper    <= cfg_i.data;
        CfgMediumUpper: cfg_q.medium_upper <= cfg_i.data;
        CfgMargin:      cfg_q.margin       <= cfg_i.data;
        CfgGainLow:     cfg_q.gain_low     <= cfg_i.data[GainW-1:0];
        CfgGainMedium:  cfg_q.gain_medium  <= cfg_i.data[GainW-1:0];
        CfgGainHigh:    cfg_q.gain_high    <= cfg_i.data[GainW-1:0];
        CfgRangeModes:  modes_q            <= cfg_i.data[ModesW-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic              s1_valid_q;
  logic [SlotW-1:0]  s1_slot_q;
  logic [CountW-1:0] s1_count_q;
  logic              out_valid_q;
  logic              out_en;
  logic              s1_adv;
  logic              in_xfer;

  assign out_en     = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && out_en;
  assign in_i.ready = !s1_valid_q || out_en;
  assign in_xfer    = in_i.valid & in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_slot_q  <= in_i.sensor_slot;
      s1_count_q <= in_i.raw_count;
    end
  end

  // Fold the slot number into the slot count
  logic [SlotW-1:0]      slot_red;
  logic [SlotIdxW+1:0]   slot_ext;
  logic [SlotIdxW-1:0]   slot_idx;
  logic [RangeW-1:0]     mode;

  always_comb begin
    slot_red = s1_slot_q;
    for (int k = 0; k < 3; k++) begin
      if ({3'b000, slot_red} >= SlotsC) slot_red = slot_red - SlotsC[SlotW-1:0];
    end
  end

  assign slot_ext = {{SlotIdxW{1'b0}}, slot_red};
  assign slot_idx = slot_ext[SlotIdxW-1:0];
  assign mode     = modes_q[{slot_red, 1'b0} +: RangeW];

  // Per-slot auto range state
  logic [RangeW-1:0] auto_range_q [SENSOR_SLOTS];
  logic [ValueW-1:0] calc_value;
  logic [RangeW-1:0] calc_next;
  logic              calc_changed;

  lsar_range_calc u_calc (
    .cfg_i           (cfg_q),
    .mode_i          (mode),
    .auto_range_i    (auto_range_q[slot_idx]),
    .raw_count_i     (s1_count_q),
    .scaled_value_o  (calc_value),
    .next_range_o    (calc_next),
    .range_changed_o (calc_changed)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SENSOR_SLOTS; i++) auto_range_q[i] <= RANGE_MEDIUM;
    end else if (modes_we) begin
      for (int i = 0; i < SENSOR_SLOTS; i++) auto_range_q[i] <= RANGE_MEDIUM;
    end else if (s1_adv && (mode == MODE_AUTO)) begin
      auto_range_q[slot_idx] <= calc_next;
    end
  end

  // Result register
  logic [ValueW-1:0] res_value_q;
  logic [RangeW-1:0] res_next_q;
  logic              res_changed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_value_q   <= calc_value;
      res_next_q    <= calc_next;
      res_changed_q <= calc_changed;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.scaled_value  = res_value_q;
  assign out_o.next_range    = res_next_q;
  assign out_o.range_changed = res_changed_q;

  // Checks
  a_auto_range_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    auto_range_q[0] != MODE_AUTO)
    else $error("auto range of slot 0 holds the auto code");

  a_modes_write_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    modes_we |=> (auto_range_q[0] == RANGE_MEDIUM))
    else $error("range_modes write did not reset auto range");

  a_fixed_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && (mode != MODE_AUTO)) |=> !res_changed_q)
    else $error("fixed-mode reading flagged a range change");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_en) |=> (s1_valid_q && $stable(s1_count_q)))
    else $error("input register dropped a reading under stall");

endmodule
